[design/salc_pkg.sv]
// Shared types and constants for the set-associative LRU cache model.
package salc_pkg;

    // Fixed field widths
    localparam int TAG_W   = 32;
    localparam int CNT_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int OUTC_W  = 2;
    localparam int SETO_W  = 6;
    localparam int IDX_W   = 2;
    localparam int CDATA_W = 8;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Register reset values
    localparam logic [2:0] SET_BITS_RST   = 3'd4;
    localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
    localparam logic [3:0] WAYS_USED_RST  = 4'd1;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [IDX_W-1:0] REG_BLOCK_BITS = 2'd1;
    localparam logic [IDX_W-1:0] REG_WAYS_USED  = 2'd2;

    // Access kinds
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_STORE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    typedef enum logic [OUTC_W-1:0] {
        OUT_HIT   = 2'd0,
        OUT_FILL  = 2'd1,
        OUT_EVICT = 2'd2
    } outcome_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_REREAD
    } state_t;

endpackage

[design/salc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/salc_lookup.sv]
// Tag compare, victim choice and LRU age update for one set row.
module salc_lookup import salc_pkg::*; #(
    parameter int MAX_WAYS = 8
) (
    input  logic [MAX_WAYS*(TAG_W+1+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] row,
    input  logic [TAG_W-1:0]                  tag,
    input  logic [$clog2(MAX_WAYS+1)-1:0]     ways,
    output logic [MAX_WAYS*(TAG_W+1+((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1))-1:0] row_next,
    output outcome_t                          outcome
);

    localparam int AGE_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ENT_W  = TAG_W + 1 + AGE_W;
    localparam int WIDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W = $clog2(MAX_WAYS + 1);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(MAX_WAYS - 1);

    logic [TAG_W-1:0]  tag_a   [MAX_WAYS];
    logic              valid_a [MAX_WAYS];
    logic [AGE_W-1:0]  age_a   [MAX_WAYS];
    logic              in_use  [MAX_WAYS];

    logic              found_hit, found_free, found_vic;
    logic [WIDX_W-1:0] hit_w, free_w, vic_w, sel_w;
    logic [AGE_W-1:0]  vic_age, hit_age;

    // unpack the row
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            tag_a[w]   = row[w*ENT_W +: TAG_W];
            valid_a[w] = row[w*ENT_W + TAG_W];
            age_a[w]   = row[w*ENT_W + TAG_W + 1 +: AGE_W];
            in_use[w]  = (WAYS_W'(w) < ways);
        end
    end

    // lowest hit, lowest free way, oldest valid way (lowest on tie)
    always_comb begin
        found_hit  = 1'b0;
        found_free = 1'b0;
        found_vic  = 1'b0;
        hit_w      = '0;
        free_w     = '0;
        vic_w      = '0;
        vic_age    = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w]) begin
                if (valid_a[w]) begin
                    if (!found_hit && tag_a[w] == tag) begin
                        found_hit = 1'b1;
                        hit_w     = WIDX_W'(w);
                    end
                    if (!found_vic || age_a[w] > vic_age) begin
                        found_vic = 1'b1;
                        vic_w     = WIDX_W'(w);
                        vic_age   = age_a[w];
                    end
                end else if (!found_free) begin
                    found_free = 1'b1;
                    free_w     = WIDX_W'(w);
                end
            end
        end
    end

    // outcome and selected way
    always_comb begin
        hit_age = age_a[hit_w];
        if (found_hit) begin
            outcome = OUT_HIT;
            sel_w   = hit_w;
        end else if (found_free) begin
            outcome = OUT_FILL;
            sel_w   = free_w;
        end else begin
            outcome = OUT_EVICT;
            sel_w   = vic_w;
        end
    end

    // updated row: selected way becomes most recent, newer ways age
    always_comb begin
        row_next = row;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (WIDX_W'(w) == sel_w) begin
                row_next[w*ENT_W + TAG_W + 1 +: AGE_W] = '0;
                if (!found_hit) begin
                    row_next[w*ENT_W +: TAG_W]  = tag;
                    row_next[w*ENT_W + TAG_W]   = 1'b1;
                end
            end else if (in_use[w] && valid_a[w] && age_a[w] < AGE_MAX &&
                         (!found_hit || age_a[w] < hit_age)) begin
                row_next[w*ENT_W + TAG_W + 1 +: AGE_W] = age_a[w] + 1'b1;
            end
        end
    end

endmodule

[design/set_assoc_lru_cache_sim_core.sv]
// Set-associative cache hit/miss/eviction model with true LRU replacement.
//
// Each input beat is one access (kind on s_tuser, byte address on s_tdata).
// Load and store give one result beat, modify gives two (the second always
// hits), kind three gives none. One set row (tag, valid and age of every way)
// lives in a single RAM word; a lookup reads the row, compares and writes it
// back. A load or store is a row read, then a compare and write-back; a
// modify adds a second lookup that rereads the row just written; a stalled
// result output holds back the write-back. After reset the RAM is cleared
// one row per cycle, 2**MAX_SET_BITS rows (64 by default), with s_tready low.
// Configuration writes are taken at any time but are meant for idle periods.
module set_assoc_lru_cache_sim_core import salc_pkg::*; #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CDATA_W-1:0]  cfg_data,
    // access input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [31:0] address
    input  logic [FUNC_W-1:0]   s_tuser,   // [1:0] func
    // result output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [103:0]        m_tdata,   // [5:0] set_index, [37:6] hit_total,
                                           // [69:38] miss_total, [101:70] evict_total,
                                           // [103:102] zero
    output logic [OUTC_W-1:0]   m_tuser,   // [1:0] outcome
    output logic                m_tlast    // last_of_run
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int AGE_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W    = MAX_WAYS * (TAG_W + 1 + AGE_W);
    localparam int WAYS_W   = $clog2(MAX_WAYS + 1);

    // configuration registers
    logic [2:0] set_bits_reg;
    logic [4:0] block_bits_reg;
    logic [3:0] ways_used_reg;

    state_t state_reg, state_next;
    logic [SET_W-1:0] clr_reg;
    logic [SET_W-1:0] set_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             pend_reg;

    logic [CNT_W-1:0] hit_cnt_reg, miss_cnt_reg, evict_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next, miss_cnt_next, evict_cnt_next;

    logic             out_valid_reg;
    outcome_t         out_outcome_reg;
    logic [SETO_W-1:0] out_set_reg;
    logic [CNT_W-1:0] out_hit_reg, out_miss_reg, out_evict_reg;
    logic             out_last_reg;

    logic             accept, lookup_go, look_fire, clr_done;
    logic [2:0]       sb_eff;
    logic [5:0]       tag_shift;
    logic [31:0]      set_full;
    logic [SET_W-1:0] acc_set;
    logic [TAG_W-1:0] acc_tag;
    logic [WAYS_W-1:0] ways_eff;

    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr, ram_raddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata, row_next;
    outcome_t         lk_outcome;

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg   <= SET_BITS_RST;
            block_bits_reg <= BLOCK_BITS_RST;
            ways_used_reg  <= WAYS_USED_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_SET_BITS:   set_bits_reg   <= cfg_data[2:0];
                REG_BLOCK_BITS: block_bits_reg <= cfg_data[4:0];
                REG_WAYS_USED:  ways_used_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective geometry
    always_comb begin
        sb_eff = (32'(set_bits_reg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_reg;
        if (ways_used_reg == 4'd0) begin
            ways_eff = WAYS_W'(1);
        end else if (32'(ways_used_reg) > MAX_WAYS) begin
            ways_eff = WAYS_W'(MAX_WAYS);
        end else begin
            ways_eff = WAYS_W'(ways_used_reg);
        end
    end

    // set index and tag of the incoming address
    always_comb begin
        set_full  = (s_tdata >> block_bits_reg) & ((32'd1 << sb_eff) - 32'd1);
        acc_set   = set_full[SET_W-1:0];
        tag_shift = 6'(block_bits_reg) + 6'(sb_eff);
        acc_tag   = (tag_shift >= 6'd32) ? '0 : (s_tdata >> tag_shift);
    end

    // handshake qualifiers
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign lookup_go = accept && (s_tuser != FUNC_NONE);
    assign look_fire = (state_reg == ST_LOOK) && (!out_valid_reg || m_tready);
    assign clr_done  = (clr_reg == SET_W'(NUM_SETS - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_done) state_next = ST_IDLE;
            ST_IDLE:   if (lookup_go) state_next = ST_LOOK;
            ST_LOOK: begin
                if (look_fire) state_next = pend_reg ? ST_REREAD : ST_IDLE;
            end
            ST_REREAD: state_next = ST_LOOK;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // RAM controls per state
    always_comb begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = set_reg;
        ram_raddr = acc_set;
        ram_wdata = row_next;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            ST_IDLE:   ram_re = lookup_go;
            ST_LOOK:   ram_we = look_fire;
            ST_REREAD: begin
                ram_re    = 1'b1;
                ram_raddr = set_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (lookup_go) begin
                pend_reg <= (s_tuser == FUNC_MODIFY);
            end else if (look_fire) begin
                pend_reg <= 1'b0;
            end
        end
    end

    // access latch
    always_ff @(posedge aclk) begin
        if (lookup_go) begin
            set_reg <= acc_set;
            tag_reg <= acc_tag;
        end
    end

    salc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    salc_lookup #(
        .MAX_WAYS (MAX_WAYS)
    ) u_lookup (
        .row      (ram_rdata),
        .tag      (tag_reg),
        .ways     (ways_eff),
        .row_next (row_next),
        .outcome  (lk_outcome)
    );

    // saturating counters
    always_comb begin
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        evict_cnt_next = evict_cnt_reg;
        if (lk_outcome == OUT_HIT) begin
            if (hit_cnt_reg != COUNT_MAX) hit_cnt_next = hit_cnt_reg + 1'b1;
        end else begin
            if (miss_cnt_reg != COUNT_MAX) miss_cnt_next = miss_cnt_reg + 1'b1;
        end
        if (lk_outcome == OUT_EVICT && evict_cnt_reg != COUNT_MAX) begin
            evict_cnt_next = evict_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
        end else if (look_fire) begin
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            evict_cnt_reg <= evict_cnt_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (look_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (look_fire) begin
            out_outcome_reg <= lk_outcome;
            out_set_reg     <= SETO_W'(set_reg);
            out_hit_reg     <= hit_cnt_next;
            out_miss_reg    <= miss_cnt_next;
            out_evict_reg   <= evict_cnt_next;
            out_last_reg    <= !pend_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_outcome_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_evict_reg, out_miss_reg, out_hit_reg, out_set_reg};

    // counters only move on a lookup, and never backward
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !$past(look_fire) |->
            $stable(hit_cnt_reg) && $stable(miss_cnt_reg) && $stable(evict_cnt_reg))
        else $error("counter changed without a lookup");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> hit_cnt_reg >= $past(hit_cnt_reg))
        else $error("hit counter went backward");

    // the second lookup of a modify always hits
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOOK && $past(state_reg) == ST_REREAD |-> lk_outcome == OUT_HIT)
        else $error("second lookup of modify missed");

    // a completed lookup always leaves a pending result
    assert property (@(posedge aclk) disable iff (!aresetn)
        look_fire |=> m_tvalid)
        else $error("lookup result lost");

endmodule
